@@ hw/rtl/rmts_pkg.sv @@
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared types and codes for the rate-monotonic task scheduler: operation,
// status and task state codes, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package rmts_pkg;

   // field widths fixed by the item format
   localparam int FUNC_W  = 2;
   localparam int PID_W   = 22;
   localparam int PER_W   = 16;
   localparam int COST_W  = 16;
   localparam int TIME_W  = 48;
   localparam int USUM_W  = 20;
   localparam int LIMIT_W = 10;
   localparam int STAT_W  = 2;
   localparam int SUM_W   = 32;
   localparam int QUO_W   = 26;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd693;
   localparam logic [9:0]         UTIL_SCALE  = 10'd1000;
   localparam logic [USUM_W-1:0]  USUM_MAX    = 20'hFFFFF;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_YIELD      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEREGISTER = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_REJECT    = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd3;

   // task states
   localparam logic [1:0] TASK_RUNNING  = 2'd0;
   localparam logic [1:0] TASK_READY    = 2'd1;
   localparam logic [1:0] TASK_SLEEPING = 2'd2;

   // table read address select
   localparam logic [1:0] RD_SEL_IDX   = 2'd0;
   localparam logic [1:0] RD_SEL_FOUND = 2'd1;
   localparam logic [1:0] RD_SEL_PRE   = 2'd2;
   localparam logic [1:0] RD_SEL_RUN   = 2'd3;

   // divider operand select
   localparam logic [1:0] DIV_SRC_NEW  = 2'd0;
   localparam logic [1:0] DIV_SRC_OLD  = 2'd1;
   localparam logic [1:0] DIV_SRC_WIDE = 2'd2;

   typedef struct packed {
      logic       latch;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd;
      logic [1:0] rd_sel;
      logic       div_load;
      logic [1:0] div_src;
      logic       sum_add;
      logic       reg_zero;
      logic       reg_scan;
      logic       reg_decide;
      logic       found_mark;
      logic       not_found;
      logic       dereg;
      logic       run_clr;
      logic       yield_write;
      logic       yield_rem;
      logic       now_inc;
      logic       tick_eval;
      logic       best_eval;
      logic       disp_apply;
      logic       pre_cap;
      logic       run_cap;
   } rmts_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              period_zero;
      logic              div_done;
      logic              idx_last;
      logic              used_i;
      logic              pid_match;
      logic              rel_le_now;
      logic              cand;
   } rmts_stat_type;

endpackage

@@ hw/rtl/rmts_divider.sv @@
// ----------------------------------------------------------------------------
// rmts_divider
// Restoring divider, one quotient bit per cycle. Narrow mode divides a
// 26-bit dividend in 26 steps, wide mode a 48-bit dividend in 48 steps.
// ----------------------------------------------------------------------------
module rmts_divider
   import rmts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              wide,
   input  logic [TIME_W-1:0] dividend,
   input  logic [PER_W-1:0]  divisor,
   output logic              done,
   output logic [TIME_W-1:0] quotient,
   output logic [PER_W-1:0]  remainder
);

   logic              busy_ff;
   logic              done_ff;
   logic [5:0]        cnt_ff;
   logic [TIME_W-1:0] quo_ff, quo_in;
   logic [PER_W-1:0]  rem_ff, rem_in;
   logic [PER_W-1:0]  dsr_ff;
   logic [PER_W:0]    trial;
   logic [PER_W:0]    diff;
   logic              ge;

   // one restoring step
   always_comb begin
      trial  = {rem_ff, quo_ff[TIME_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      ge     = (trial >= {1'b0, dsr_ff});
      rem_in = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
      quo_in = {quo_ff[TIME_W-2:0], ge};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            busy_ff <= 1'b1;
            cnt_ff  <= wide ? 6'd47 : 6'd25;
         end else if (busy_ff) begin
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

   // operands
   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= wide ? dividend : {dividend[QUO_W-1:0], {(TIME_W-QUO_W){1'b0}}};
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/rmts_datapath.sv @@
// ----------------------------------------------------------------------------
// rmts_datapath
// Task table, time base, admission accumulator, dispatch search registers
// and result registers, driven by commands from the controller.
// ----------------------------------------------------------------------------
module rmts_datapath
   import rmts_pkg::*;
#(
   parameter int MAX_TASKS = 16,
   parameter int IDX_W     = 4
)
(
   input  logic               clock,
   input  logic               reset,
   input  rmts_cmd_type       cmd,
   output rmts_stat_type      stat,
   input  logic               csr_wr,
   input  logic [LIMIT_W-1:0] csr_data,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [PID_W-1:0]   req_pid,
   input  logic [PER_W-1:0]   req_period,
   input  logic [COST_W-1:0]  req_task_cost,
   output logic [STAT_W-1:0]  rsp_status,
   output logic               rsp_running_valid,
   output logic [PID_W-1:0]   rsp_running_pid,
   output logic               rsp_preempted_valid,
   output logic [PID_W-1:0]   rsp_preempted_pid,
   output logic [USUM_W-1:0]  rsp_utilization_sum
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TASKS - 1);

   // configuration and latched request
   logic [LIMIT_W-1:0] limit_ff;
   logic [FUNC_W-1:0]  func_ff;
   logic [PID_W-1:0]   pid_ff;
   logic [PER_W-1:0]   per_ff;
   logic [COST_W-1:0]  cost_ff;

   // table storage
   logic [PID_W-1:0]  mem_pid  [MAX_TASKS];
   logic [PER_W-1:0]  mem_per  [MAX_TASKS];
   logic [COST_W-1:0] mem_cost [MAX_TASKS];
   logic [TIME_W-1:0] mem_rel  [MAX_TASKS];
   logic [PID_W-1:0]  rd_pid_ff;
   logic [PER_W-1:0]  rd_per_ff;
   logic [COST_W-1:0] rd_cost_ff;
   logic [TIME_W-1:0] rd_rel_ff;

   logic [MAX_TASKS-1:0] used_ff;
   logic [MAX_TASKS-1:0] armed_ff;
   logic [1:0]           tstate_ff [MAX_TASKS];

   // scheduler state
   logic [TIME_W-1:0] now_ff;
   logic              run_v_ff;
   logic [IDX_W-1:0]  run_slot_ff;

   // scan and work registers
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  free_ff;
   logic              free_v_ff;
   logic [IDX_W-1:0]  found_ff;
   logic [IDX_W-1:0]  best_ff;
   logic              best_v_ff;
   logic [PER_W-1:0]  best_per_ff;
   logic [IDX_W-1:0]  pre_slot_ff;
   logic [SUM_W-1:0]  sum_ff;

   // result registers
   logic [STAT_W-1:0] status_ff;
   logic              pre_v_ff;
   logic [PID_W-1:0]  pre_pid_ff;
   logic [PID_W-1:0]  run_pid_ff;
   logic [USUM_W-1:0] usum_ff;

   // divider hookup
   logic              div_done;
   logic [TIME_W-1:0] div_quo;
   logic [PER_W-1:0]  div_rem;
   logic [TIME_W-1:0] div_dividend;
   logic [PER_W-1:0]  div_divisor;
   logic [QUO_W-1:0]  scaled_cost;

   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  rel_addr;
   logic [TIME_W-1:0] rel_wdata;
   logic              rel_we;
   logic              rel_le_now;
   logic              change;
   logic [1:0]        st_i;

   // divider operands
   always_comb begin
      scaled_cost  = QUO_W'(((cmd.div_src == DIV_SRC_NEW) ? cost_ff : rd_cost_ff)
                     * UTIL_SCALE);
      div_dividend = {{(TIME_W-QUO_W){1'b0}}, scaled_cost};
      div_divisor  = rd_per_ff;
      case (cmd.div_src)
         DIV_SRC_NEW:  div_divisor = per_ff;
         DIV_SRC_WIDE: div_dividend = now_ff - rd_rel_ff;
         default:      div_divisor = rd_per_ff;
      endcase
   end

   rmts_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .load      (cmd.div_load),
      .wide      (cmd.div_src == DIV_SRC_WIDE),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // read address and release write port
   always_comb begin
      case (cmd.rd_sel)
         RD_SEL_IDX:   rd_addr = idx_ff;
         RD_SEL_FOUND: rd_addr = found_ff;
         RD_SEL_PRE:   rd_addr = pre_slot_ff;
         default:      rd_addr = run_slot_ff;
      endcase
      rel_we    = cmd.reg_decide || cmd.yield_write;
      rel_addr  = cmd.reg_decide ? free_ff : found_ff;
      if (cmd.reg_decide)
         rel_wdata = now_ff;
      else if (cmd.yield_rem)
         rel_wdata = now_ff - {{(TIME_W-PER_W){1'b0}}, div_rem}
                     + {{(TIME_W-PER_W){1'b0}}, rd_per_ff};
      else
         rel_wdata = rd_rel_ff + {{(TIME_W-PER_W){1'b0}}, rd_per_ff};
   end

   // status toward controller
   always_comb begin
      st_i             = tstate_ff[idx_ff];
      rel_le_now       = (rd_rel_ff <= now_ff);
      stat.func        = func_ff;
      stat.period_zero = (per_ff == '0);
      stat.div_done    = div_done;
      stat.idx_last    = (idx_ff == IDX_LAST);
      stat.used_i      = used_ff[idx_ff];
      stat.pid_match   = (rd_pid_ff == pid_ff);
      stat.rel_le_now  = rel_le_now;
      stat.cand        = used_ff[idx_ff]
                         && (st_i == TASK_READY || st_i == TASK_RUNNING)
                         && (!best_v_ff || rd_per_ff < best_per_ff);
      change           = !(run_v_ff && best_v_ff && best_ff == run_slot_ff)
                         && !(!run_v_ff && !best_v_ff);
   end

   // table memories
   always_ff @(posedge clock) begin
      if (cmd.reg_decide && free_v_ff && sum_ff <= SUM_W'(limit_ff)) begin
         mem_pid[free_ff]  <= pid_ff;
         mem_per[free_ff]  <= per_ff;
         mem_cost[free_ff] <= cost_ff;
      end
      if (rel_we && (cmd.yield_write || (free_v_ff && sum_ff <= SUM_W'(limit_ff))))
         mem_rel[rel_addr] <= rel_wdata;
      if (cmd.rd) begin
         rd_pid_ff  <= mem_pid[rd_addr];
         rd_per_ff  <= mem_per[rd_addr];
         rd_cost_ff <= mem_cost[rd_addr];
         rd_rel_ff  <= mem_rel[rd_addr];
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset)
         limit_ff <= LIMIT_RESET;
      else if (csr_wr)
         limit_ff <= csr_data;
   end

   // request latch, scan index and work registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff <= req_func;
         pid_ff  <= req_pid;
         per_ff  <= req_period;
         cost_ff <= req_task_cost;
      end
      if (cmd.latch || cmd.idx_clr)
         idx_ff <= '0;
      else if (cmd.idx_inc)
         idx_ff <= idx_ff + 1'b1;
      if (cmd.latch) begin
         sum_ff    <= '0;
         free_v_ff <= 1'b0;
         best_v_ff <= 1'b0;
      end else begin
         if (cmd.sum_add)
            sum_ff <= sum_ff + SUM_W'(div_quo[QUO_W-1:0]) + 1'b1;
         if (cmd.reg_scan && !used_ff[idx_ff] && !free_v_ff) begin
            free_ff   <= idx_ff;
            free_v_ff <= 1'b1;
         end
         if (cmd.best_eval && stat.cand) begin
            best_ff     <= idx_ff;
            best_per_ff <= rd_per_ff;
            best_v_ff   <= 1'b1;
         end
      end
      if (cmd.found_mark)
         found_ff <= idx_ff;
      if (cmd.disp_apply)
         pre_slot_ff <= run_slot_ff;
   end

   // task flags, time base and running task
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         armed_ff    <= '0;
         now_ff      <= '0;
         run_v_ff    <= 1'b0;
         run_slot_ff <= '0;
      end else begin
         // admit new task
         if (cmd.reg_decide && free_v_ff && sum_ff <= SUM_W'(limit_ff)) begin
            used_ff[free_ff]   <= 1'b1;
            armed_ff[free_ff]  <= 1'b0;
            tstate_ff[free_ff] <= TASK_SLEEPING;
         end
         if (cmd.dereg) begin
            used_ff[found_ff]  <= 1'b0;
            armed_ff[found_ff] <= 1'b0;
            run_v_ff           <= 1'b0;
         end
         if (cmd.run_clr)
            run_v_ff <= 1'b0;
         // yield puts the task to sleep until its next release
         if (cmd.yield_write) begin
            armed_ff[found_ff]  <= 1'b1;
            tstate_ff[found_ff] <= TASK_SLEEPING;
         end
         if (cmd.now_inc)
            now_ff <= now_ff + 1'b1;
         // release due tasks
         if (cmd.tick_eval && used_ff[idx_ff] && armed_ff[idx_ff] && rel_le_now) begin
            tstate_ff[idx_ff] <= TASK_READY;
            armed_ff[idx_ff]  <= 1'b0;
         end
         // dispatch and preemption
         if (cmd.disp_apply && change) begin
            if (run_v_ff)
               tstate_ff[run_slot_ff] <= TASK_READY;
            if (best_v_ff) begin
               tstate_ff[best_ff] <= TASK_RUNNING;
               run_slot_ff        <= best_ff;
               run_v_ff           <= 1'b1;
            end else begin
               run_v_ff <= 1'b0;
            end
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         status_ff <= STATUS_DONE;
         usum_ff   <= '0;
         pre_v_ff  <= 1'b0;
      end else begin
         if (cmd.reg_zero)
            status_ff <= STATUS_REJECT;
         if (cmd.not_found)
            status_ff <= STATUS_NOT_FOUND;
         if (cmd.reg_decide) begin
            usum_ff <= (sum_ff > SUM_W'(USUM_MAX)) ? USUM_MAX : sum_ff[USUM_W-1:0];
            if (sum_ff > SUM_W'(limit_ff))
               status_ff <= STATUS_REJECT;
            else if (!free_v_ff)
               status_ff <= STATUS_FULL;
         end
         if (cmd.disp_apply && change && run_v_ff)
            pre_v_ff <= 1'b1;
      end
      if (cmd.pre_cap)
         pre_pid_ff <= pre_v_ff ? rd_pid_ff : '0;
      if (cmd.run_cap)
         run_pid_ff <= run_v_ff ? rd_pid_ff : '0;
   end

   assign rsp_status          = status_ff;
   assign rsp_running_valid   = run_v_ff;
   assign rsp_running_pid     = run_pid_ff;
   assign rsp_preempted_valid = pre_v_ff;
   assign rsp_preempted_pid   = pre_pid_ff;
   assign rsp_utilization_sum = usum_ff;

endmodule

@@ hw/rtl/rmts_controller.sv @@
// ----------------------------------------------------------------------------
// rmts_controller
// Sequencer for one request: operation phase, table scans, divider waits,
// dispatch search and result strobe.
// ----------------------------------------------------------------------------
module rmts_controller
   import rmts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   output rmts_cmd_type  cmd,
   input  rmts_stat_type stat
);

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_DECODE    = 5'd1;
   localparam logic [4:0] S_R_WAITNEW = 5'd2;
   localparam logic [4:0] S_R_READ    = 5'd3;
   localparam logic [4:0] S_R_EVAL    = 5'd4;
   localparam logic [4:0] S_R_WAITOLD = 5'd5;
   localparam logic [4:0] S_R_DECIDE  = 5'd6;
   localparam logic [4:0] S_F_READ    = 5'd7;
   localparam logic [4:0] S_F_EVAL    = 5'd8;
   localparam logic [4:0] S_X_DEREG   = 5'd9;
   localparam logic [4:0] S_Y_READ    = 5'd10;
   localparam logic [4:0] S_Y_EVAL    = 5'd11;
   localparam logic [4:0] S_Y_WAIT    = 5'd12;
   localparam logic [4:0] S_T_READ    = 5'd13;
   localparam logic [4:0] S_T_EVAL    = 5'd14;
   localparam logic [4:0] S_D_START   = 5'd15;
   localparam logic [4:0] S_D_READ    = 5'd16;
   localparam logic [4:0] S_D_EVAL    = 5'd17;
   localparam logic [4:0] S_D_APPLY   = 5'd18;
   localparam logic [4:0] S_D_RDPRE   = 5'd19;
   localparam logic [4:0] S_D_CAPPRE  = 5'd20;
   localparam logic [4:0] S_D_RDRUN   = 5'd21;
   localparam logic [4:0] S_D_CAPRUN  = 5'd22;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.func)
               FUNC_REGISTER: begin
                  if (stat.period_zero) begin
                     cmd.reg_zero = 1'b1;
                     state_in     = S_D_START;
                  end else begin
                     cmd.div_load = 1'b1;
                     cmd.div_src  = DIV_SRC_NEW;
                     state_in     = S_R_WAITNEW;
                  end
               end
               FUNC_TICK: begin
                  cmd.now_inc = 1'b1;
                  state_in    = S_T_READ;
               end
               default: state_in = S_F_READ;
            endcase
         end
         // admission sum over the table
         S_R_WAITNEW: begin
            if (stat.div_done) begin
               cmd.sum_add = 1'b1;
               state_in    = S_R_READ;
            end
         end
         S_R_READ: begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = RD_SEL_IDX;
            state_in   = S_R_EVAL;
         end
         S_R_EVAL: begin
            cmd.reg_scan = 1'b1;
            if (stat.used_i) begin
               cmd.div_load = 1'b1;
               cmd.div_src  = DIV_SRC_OLD;
               state_in     = S_R_WAITOLD;
            end else if (stat.idx_last) begin
               state_in = S_R_DECIDE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_R_READ;
            end
         end
         S_R_WAITOLD: begin
            if (stat.div_done) begin
               cmd.sum_add = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_R_DECIDE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_R_READ;
               end
            end
         end
         S_R_DECIDE: begin
            cmd.reg_decide = 1'b1;
            state_in       = S_D_START;
         end
         // pid lookup
         S_F_READ: begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = RD_SEL_IDX;
            state_in   = S_F_EVAL;
         end
         S_F_EVAL: begin
            if (stat.used_i && stat.pid_match) begin
               cmd.found_mark = 1'b1;
               state_in = (stat.func == FUNC_DEREGISTER) ? S_X_DEREG : S_Y_READ;
            end else if (stat.idx_last) begin
               cmd.not_found = 1'b1;
               state_in      = S_D_START;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_F_READ;
            end
         end
         S_X_DEREG: begin
            cmd.dereg = 1'b1;
            state_in  = S_D_START;
         end
         // next release for yield
         S_Y_READ: begin
            cmd.rd      = 1'b1;
            cmd.rd_sel  = RD_SEL_FOUND;
            cmd.run_clr = 1'b1;
            state_in    = S_Y_EVAL;
         end
         S_Y_EVAL: begin
            if (stat.rel_le_now) begin
               cmd.div_load = 1'b1;
               cmd.div_src  = DIV_SRC_WIDE;
               state_in     = S_Y_WAIT;
            end else begin
               cmd.yield_write = 1'b1;
               state_in        = S_D_START;
            end
         end
         S_Y_WAIT: begin
            cmd.div_src = DIV_SRC_WIDE;
            if (stat.div_done) begin
               cmd.yield_write = 1'b1;
               cmd.yield_rem   = 1'b1;
               state_in        = S_D_START;
            end
         end
         // release check on tick
         S_T_READ: begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = RD_SEL_IDX;
            state_in   = S_T_EVAL;
         end
         S_T_EVAL: begin
            cmd.tick_eval = 1'b1;
            if (stat.idx_last) begin
               state_in = S_D_START;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_T_READ;
            end
         end
         // dispatch search
         S_D_START: begin
            cmd.idx_clr = 1'b1;
            state_in    = S_D_READ;
         end
         S_D_READ: begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = RD_SEL_IDX;
            state_in   = S_D_EVAL;
         end
         S_D_EVAL: begin
            cmd.best_eval = 1'b1;
            if (stat.idx_last) begin
               state_in = S_D_APPLY;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_D_READ;
            end
         end
         S_D_APPLY: begin
            cmd.disp_apply = 1'b1;
            state_in       = S_D_RDPRE;
         end
         S_D_RDPRE: begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = RD_SEL_PRE;
            state_in   = S_D_CAPPRE;
         end
         S_D_CAPPRE: begin
            cmd.pre_cap = 1'b1;
            state_in    = S_D_RDRUN;
         end
         S_D_RDRUN: begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = RD_SEL_RUN;
            state_in   = S_D_CAPRUN;
         end
         S_D_CAPRUN: begin
            cmd.run_cap  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start) |=> (state_ff == S_DECODE))
      else $error("accepted request did not start decode");
   a_strobe_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while busy");
   a_strobe_after_capture: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_D_CAPRUN))
      else $error("result strobe without finished dispatch");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");
`endif

endmodule

@@ hw/rtl/rate_monotonic_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler
// Rate-monotonic scheduler with utilization admission: task table,
// register/yield/deregister/tick requests, least-period dispatch.
//
//   channel   direction  handshake            payload
//   req_      in         start, busy          func, pid, period, task_cost
//   rsp_      out        rsp_valid strobe     status, running/preempted, sum
//   csr_      in         csr_valid, ready     admission limit
//
// One request at a time; busy is high from acceptance until the result.
// Busy time: register divides the new cost, then reads every slot, with a
// division per used slot; yield reads slots up to the match, plus a division
// when the release has passed; deregister reads slots up to the match; tick
// or missing pid reads every slot. Every request then adds a dispatch scan
// of every slot. The serial divider and the single table read port set this.
// Reset clears the table flags, time and running task; no clearing pass.
// The result is strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module rate_monotonic_task_scheduler
   import rmts_pkg::*;
#(
   parameter int MAX_TASKS = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [PID_W-1:0]   req_pid,
   input  logic [PER_W-1:0]   req_period,
   input  logic [COST_W-1:0]  req_task_cost,
   output logic               rsp_valid,
   output logic [STAT_W-1:0]  rsp_status,
   output logic               rsp_running_valid,
   output logic [PID_W-1:0]   rsp_running_pid,
   output logic               rsp_preempted_valid,
   output logic [PID_W-1:0]   rsp_preempted_pid,
   output logic [USUM_W-1:0]  rsp_utilization_sum,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_TASKS);

   rmts_cmd_type  cmd;
   rmts_stat_type stat;

   // configuration taken only between requests
   assign csr_ready = ~busy;

   rmts_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   rmts_datapath #(
      .MAX_TASKS (MAX_TASKS),
      .IDX_W     (IDX_W)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_wr              (csr_valid && csr_ready),
      .csr_data            (csr_data),
      .req_func            (req_func),
      .req_pid             (req_pid),
      .req_period          (req_period),
      .req_task_cost       (req_task_cost),
      .rsp_status          (rsp_status),
      .rsp_running_valid   (rsp_running_valid),
      .rsp_running_pid     (rsp_running_pid),
      .rsp_preempted_valid (rsp_preempted_valid),
      .rsp_preempted_pid   (rsp_preempted_pid),
      .rsp_utilization_sum (rsp_utilization_sum)
   );

endmodule
